// ===== hdl/tss_pkg.sv =====
// Shared types, widths and codes for the timed setpoint sequencer.
// No dependencies; used by tss_ctrl, tss_dp and timed_setpoint_sequencer.
package tss_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int POS_BITS    = 32;
	localparam int TIME_BITS   = 32;

	localparam int ADDR_W  = $clog2(MAX_SAMPLES);
	localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int PLAY_W  = $clog2(MAX_SAMPLES + 2);
	localparam int REP_W   = 16;
	localparam int DWELL_W = 16;
	localparam int MODE_W  = 2;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 16;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam logic [REP_W-1:0]     REP_MAX  = {REP_W{1'b1}};

	typedef logic [2:0] op_t;
	localparam op_t OP_CLEAR   = 3'd0;
	localparam op_t OP_WRITE   = 3'd1;
	localparam op_t OP_TICK    = 3'd2;
	localparam op_t OP_START   = 3'd3;
	localparam op_t OP_STOP    = 3'd4;
	localparam op_t OP_TRIGGER = 3'd5;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_NONE = 2'd0;
	localparam cmd_t CMD_MOVE = 2'd1;
	localparam cmd_t CMD_STOP = 2'd2;

	typedef logic [MODE_W-1:0] mode_t;
	localparam mode_t MODE_CONTINUOUS = 2'd0;
	localparam mode_t MODE_ONCE       = 2'd1;
	localparam mode_t MODE_EACH       = 2'd2;
	localparam mode_t MODE_STREAM     = 2'd3;

	typedef logic [CIDX_W-1:0] cidx_t;
	localparam cidx_t CFG_TRIGGER_MODE = 2'd0;
	localparam cidx_t CFG_REPEAT_TOTAL = 2'd1;
	localparam cidx_t CFG_DWELL_MS     = 2'd2;
	localparam cidx_t CFG_USE_TIME     = 2'd3;

	typedef struct packed {
		logic capture;
		logic exec;
		logic tk_begin;
		logic sc_load;
		logic sc_here;
		logic sc_next;
		logic end_pass;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic in_is_tick;
		logic tick_active;
		logic scan_none;
		logic is_last;
		logic pair_hit;
	} sts_t;

endpackage

// ===== hdl/timed_setpoint_sequencer.sv =====
// Timed setpoint sequencer: one beat in, one result beat out; table RAM scanned per tick.
// Non-tick beats pass capture, execute and result load; ticks that do nothing pass capture,
// tick begin and result load; a scanning tick tests table entries from the playback position
// in here and next steps until the last entry or a later sample's time ends the scan.
// Throughput: one beat at a time; the next beat is taken the cycle after its result is loaded.
// Reset: state cleared, ready set, config registers at defaults; sample tables are not cleared.
module timed_setpoint_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  logic [31:0]        sample_time_ms,
	input  logic signed [31:0] sample_position,
	input  logic               list_end,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         command,
	output logic signed [31:0] target_position,
	output logic [10:0]        playback_index,
	output logic [15:0]        repeat_index,
	output logic               is_ready,
	output logic [10:0]        entry_count
);

	tss_pkg::ctl_t ctl;
	tss_pkg::sts_t sts;

	tss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	tss_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.opcode          (opcode),
		.sample_time_ms  (sample_time_ms),
		.sample_position (sample_position),
		.list_end        (list_end),
		.now_ms          (now_ms),
		.ctl             (ctl),
		.sts             (sts),
		.command         (command),
		.target_position (target_position),
		.playback_index  (playback_index),
		.repeat_index    (repeat_index),
		.is_ready        (is_ready),
		.entry_count     (entry_count)
	);

endmodule

// ===== hdl/tss_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module tss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== hdl/tss_ctrl.sv =====
// Sequencer state machine: item handshake, tick scan sequencing, result beat.
// Depends on tss_pkg.
module tss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  tss_pkg::sts_t sts,
	output tss_pkg::ctl_t ctl
);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_EXEC     = 8'b0000_0010,
		ST_TK_BEGIN = 8'b0000_0100,
		ST_SC_LOAD  = 8'b0000_1000,
		ST_SC_HERE  = 8'b0001_0000,
		ST_SC_NEXT  = 8'b0010_0000,
		ST_END_PASS = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = sts.in_is_tick ? ST_TK_BEGIN : ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = ST_DONE;
			end
			ST_TK_BEGIN: begin
				ctl.tk_begin = 1'b1;
				if (!sts.tick_active)
					state_d = ST_DONE;
				else if (sts.scan_none)
					state_d = ST_END_PASS;
				else
					state_d = ST_SC_LOAD;
			end
			ST_SC_LOAD: begin
				ctl.sc_load = 1'b1;
				state_d     = ST_SC_HERE;
			end
			ST_SC_HERE: begin
				ctl.sc_here = 1'b1;
				state_d     = sts.is_last ? ST_END_PASS : ST_SC_NEXT;
			end
			ST_SC_NEXT: begin
				ctl.sc_next = 1'b1;
				state_d     = sts.pair_hit ? ST_END_PASS : ST_SC_HERE;
			end
			ST_END_PASS: begin
				ctl.end_pass = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/tss_dp.sv =====
// Datapath: config registers, sequencer state, sample tables, scan compare, result register.
// Depends on tss_pkg and tss_ram.
module tss_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic [2:0]           opcode,
	input  logic [31:0]          sample_time_ms,
	input  logic signed [31:0]   sample_position,
	input  logic                 list_end,
	input  logic [31:0]          now_ms,
	input  tss_pkg::ctl_t        ctl,
	output tss_pkg::sts_t        sts,
	output logic [1:0]           command,
	output logic signed [31:0]   target_position,
	output logic [10:0]          playback_index,
	output logic [15:0]          repeat_index,
	output logic                 is_ready,
	output logic [10:0]          entry_count
);

	localparam int PROD_W = tss_pkg::DWELL_W + tss_pkg::COUNT_W;
	localparam int EXT_W  = PROD_W + tss_pkg::TIME_BITS;

	// configuration
	tss_pkg::mode_t                mode_q;
	logic [tss_pkg::REP_W-1:0]     rep_total_q;
	logic [tss_pkg::DWELL_W-1:0]   dwell_q;
	logic                          use_time_q;

	// sequencer state
	logic [tss_pkg::COUNT_W-1:0]   count_q;
	logic [tss_pkg::COUNT_W-1:0]   slot_q;
	logic [tss_pkg::PLAY_W-1:0]    play_q;
	logic [tss_pkg::REP_W-1:0]     passes_q;
	logic                          ready_q;
	logic [tss_pkg::TIME_BITS-1:0] run_start_q;

	// captured beat and scan registers
	tss_pkg::op_t                  op_q;
	logic [tss_pkg::TIME_BITS-1:0] st_q;
	logic signed [tss_pkg::POS_BITS-1:0] sp_q;
	logic                          le_q;
	logic [tss_pkg::TIME_BITS-1:0] now_q;
	logic [tss_pkg::TIME_BITS-1:0] elapsed_q;
	logic [tss_pkg::COUNT_W-1:0]   idx_q;
	logic [tss_pkg::TIME_BITS-1:0] here_q;
	logic [tss_pkg::POS_BITS-1:0]  hpos_q;
	tss_pkg::cmd_t                 res_cmd_q;
	logic [tss_pkg::POS_BITS-1:0]  res_pos_q;

	// result register
	tss_pkg::cmd_t                 command_q;
	logic [31:0]                   target_q;
	logic [10:0]                   playback_q;
	logic [15:0]                   repeat_q;
	logic                          ready_out_q;
	logic [10:0]                   entry_q;

	// tables
	logic                          ram_we;
	logic [tss_pkg::ADDR_W-1:0]    ram_addr;
	logic [tss_pkg::TIME_BITS-1:0] time_wdata, time_rdata;
	logic [tss_pkg::POS_BITS-1:0]  pos_rdata;

	logic [PROD_W-1:0]             dwell_prod;
	logic [EXT_W-1:0]              prod_ext;
	logic [tss_pkg::TIME_BITS-1:0] dwell_time;
	logic                          room;
	logic [tss_pkg::COUNT_W-1:0]   slot_after;
	logic                          trig_ok;
	logic [tss_pkg::REP_W-1:0]     reps;
	logic [tss_pkg::REP_W-1:0]     passes_inc;
	logic [tss_pkg::COUNT_W:0]     idx_inc;
	logic [tss_pkg::PLAY_W-1:0]    play_hit;
	logic                          here_hit;
	logic                          is_write;

	tss_ram #(.WIDTH(tss_pkg::TIME_BITS), .DEPTH(tss_pkg::MAX_SAMPLES)) u_time_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (time_wdata),
		.rdata (time_rdata)
	);

	tss_ram #(.WIDTH(tss_pkg::POS_BITS), .DEPTH(tss_pkg::MAX_SAMPLES)) u_pos_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (sp_q),
		.rdata (pos_rdata)
	);

	assign dwell_prod = PROD_W'(dwell_q) * PROD_W'(slot_q);
	assign prod_ext   = EXT_W'(dwell_prod);
	assign dwell_time = (prod_ext > EXT_W'(tss_pkg::TIME_MAX)) ? tss_pkg::TIME_MAX
	                                                           : tss_pkg::TIME_BITS'(prod_ext);
	assign time_wdata = use_time_q ? st_q : dwell_time;

	assign room       = (slot_q < tss_pkg::COUNT_W'(tss_pkg::MAX_SAMPLES));
	assign slot_after = room ? slot_q + tss_pkg::COUNT_W'(1) : slot_q;
	assign is_write   = (op_q == tss_pkg::OP_WRITE);
	assign ram_we     = ctl.exec && is_write && room;

	always_comb begin
		if (ctl.exec)
			ram_addr = slot_q[tss_pkg::ADDR_W-1:0];
		else if (ctl.sc_load)
			ram_addr = idx_q[tss_pkg::ADDR_W-1:0];
		else
			ram_addr = idx_inc[tss_pkg::ADDR_W-1:0];
	end

	assign trig_ok = ready_q && (count_q != '0) &&
	                 ((mode_q != tss_pkg::MODE_ONCE) || ((play_q == '0) && (passes_q == '0)));
	assign reps       = (rep_total_q == '0) ? tss_pkg::REP_W'(1) : rep_total_q;
	assign passes_inc = (passes_q == tss_pkg::REP_MAX) ? passes_q
	                                                   : passes_q + tss_pkg::REP_W'(1);
	assign idx_inc    = (tss_pkg::COUNT_W+1)'(idx_q) + (tss_pkg::COUNT_W+1)'(1);
	assign play_hit   = tss_pkg::PLAY_W'(idx_q) + tss_pkg::PLAY_W'(2);
	assign here_hit   = (time_rdata <= elapsed_q);

	assign sts.in_is_tick  = (opcode == tss_pkg::OP_TICK);
	assign sts.tick_active = ready_q && (play_q != '0) && (count_q != '0);
	assign sts.scan_none   = (play_q > tss_pkg::PLAY_W'(count_q));
	assign sts.is_last     = (idx_inc >= (tss_pkg::COUNT_W+1)'(count_q));
	assign sts.pair_hit    = (here_q <= elapsed_q) && (time_rdata > elapsed_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= tss_pkg::MODE_EACH;
			rep_total_q <= tss_pkg::REP_W'(1);
			dwell_q     <= tss_pkg::DWELL_W'(100);
			use_time_q  <= 1'b0;
			count_q     <= '0;
			slot_q      <= '0;
			play_q      <= '0;
			passes_q    <= '0;
			ready_q     <= 1'b1;
			run_start_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tss_pkg::CFG_TRIGGER_MODE: mode_q      <= cfg_data[tss_pkg::MODE_W-1:0];
					tss_pkg::CFG_REPEAT_TOTAL: rep_total_q <= cfg_data;
					tss_pkg::CFG_DWELL_MS:     dwell_q     <= cfg_data;
					tss_pkg::CFG_USE_TIME:     use_time_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (ctl.exec) begin
				unique case (op_q)
					tss_pkg::OP_CLEAR: begin
						count_q  <= '0;
						slot_q   <= '0;
						play_q   <= '0;
						passes_q <= '0;
					end
					tss_pkg::OP_WRITE: begin
						if (le_q) begin
							count_q <= slot_after;
							slot_q  <= '0;
							if (slot_after != '0) begin
								if (mode_q == tss_pkg::MODE_CONTINUOUS ||
								    mode_q == tss_pkg::MODE_STREAM) begin
									if (ready_q) begin
										play_q   <= tss_pkg::PLAY_W'(1);
										passes_q <= '0;
									end
								end else if (mode_q == tss_pkg::MODE_EACH) begin
									play_q   <= '0;
									passes_q <= '0;
								end else begin
									ready_q <= 1'b0;
								end
							end
						end else begin
							slot_q <= slot_after;
						end
					end
					tss_pkg::OP_START: begin
						if (count_q != '0) begin
							ready_q  <= 1'b1;
							passes_q <= '0;
							play_q   <= (mode_q == tss_pkg::MODE_CONTINUOUS)
							            ? tss_pkg::PLAY_W'(1) : '0;
						end
					end
					tss_pkg::OP_STOP: begin
						ready_q <= 1'b0;
					end
					tss_pkg::OP_TRIGGER: begin
						if (trig_ok) begin
							play_q   <= tss_pkg::PLAY_W'(1);
							passes_q <= '0;
						end
					end
					default: ;
				endcase
			end
			if (ctl.tk_begin && sts.tick_active && (play_q == tss_pkg::PLAY_W'(1)))
				run_start_q <= now_q;
			if ((ctl.sc_here && sts.is_last && here_hit) || (ctl.sc_next && sts.pair_hit))
				play_q <= play_hit;
			if (ctl.end_pass && (play_q > tss_pkg::PLAY_W'(count_q))) begin
				if (passes_inc < reps) begin
					passes_q <= passes_inc;
					play_q   <= tss_pkg::PLAY_W'(1);
				end else if (mode_q == tss_pkg::MODE_CONTINUOUS) begin
					if (trig_ok) begin
						play_q   <= tss_pkg::PLAY_W'(1);
						passes_q <= '0;
					end else begin
						passes_q <= passes_inc;
					end
				end else if (mode_q == tss_pkg::MODE_ONCE) begin
					passes_q <= passes_inc;
					ready_q  <= 1'b0;
				end else begin
					play_q   <= '0;
					passes_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q      <= opcode;
			st_q      <= tss_pkg::TIME_BITS'(sample_time_ms);
			sp_q      <= tss_pkg::POS_BITS'(sample_position);
			le_q      <= list_end;
			now_q     <= tss_pkg::TIME_BITS'(now_ms);
			res_cmd_q <= tss_pkg::CMD_NONE;
			res_pos_q <= '0;
		end
		if (ctl.exec) begin
			if (op_q == tss_pkg::OP_STOP)
				res_cmd_q <= tss_pkg::CMD_STOP;
			else if (is_write && le_q && (slot_after != '0) && (mode_q == tss_pkg::MODE_ONCE))
				res_cmd_q <= tss_pkg::CMD_STOP;
		end
		if (ctl.tk_begin) begin
			idx_q     <= tss_pkg::COUNT_W'(play_q - tss_pkg::PLAY_W'(1));
			elapsed_q <= (play_q == tss_pkg::PLAY_W'(1)) ? '0 : now_q - run_start_q;
		end
		if (ctl.sc_here) begin
			here_q <= time_rdata;
			hpos_q <= pos_rdata;
			if (sts.is_last && here_hit) begin
				res_cmd_q <= tss_pkg::CMD_MOVE;
				res_pos_q <= pos_rdata;
			end
		end
		if (ctl.sc_next) begin
			if (sts.pair_hit) begin
				res_cmd_q <= tss_pkg::CMD_MOVE;
				res_pos_q <= hpos_q;
			end else begin
				idx_q <= idx_inc[tss_pkg::COUNT_W-1:0];
			end
		end
		if (ctl.load_out) begin
			command_q   <= res_cmd_q;
			target_q    <= 32'(res_pos_q);
			playback_q  <= 11'(play_q);
			repeat_q    <= 16'(passes_q);
			ready_out_q <= ready_q;
			entry_q     <= 11'(count_q);
		end
	end

	assign command         = command_q;
	assign target_position = target_q;
	assign playback_index  = playback_q;
	assign repeat_index    = repeat_q;
	assign is_ready        = ready_out_q;
	assign entry_count     = entry_q;

endmodule
